@@ sv/satl_pkg.sv @@
// Shared types and constants of the set-associative cache tag lookup.
// No dependencies; imported by satl_match and the top module.
package satl_pkg;

  localparam int SETS       = 128;
  localparam int WAYS       = 8;
  localparam int LINE_BYTES = 64;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 3;
  localparam int MAX_LEN = 4;
  localparam int SETO_W  = 7;
  localparam int WAYO_W  = 3;

  localparam int OFS_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int TAG_W = ADDR_W - OFS_W - SET_W;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] piece_address;
    logic [LEN_W-1:0]  piece_length;
    logic [SETO_W-1:0] set_index;
    logic              hit;
    logic [WAYO_W-1:0] way;
    logic              line_fill;
    logic              write_through;
    logic              last;
  } rsp_t;

  // One directory row holds a whole set.
  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][TAG_W-1:0] tag;
  } dir_row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             fill;
  } lkp_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_READ
  } state_t;

endpackage

@@ sv/satl_dir_ram.sv @@
// Generic single-clock RAM, one write and one read port, registered read data.
// No dependencies.
module satl_dir_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/satl_match.sv @@
// Tag compare, hit/victim way selection and row update for one set.
// Depends on satl_pkg.
module satl_match (
  input  satl_pkg::dir_row_t               row,
  input  logic [satl_pkg::TAG_W-1:0]       tag,
  input  logic                             action,
  output satl_pkg::lkp_res_t               res,
  output satl_pkg::dir_row_t               row_nxt
);
  import satl_pkg::*;

  logic [WAYS-1:0]  match;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic             any_free;
  logic [WAY_W-1:0] victim;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row.valid[w] && (row.tag[w] == tag);
    end
  end

  // lowest-numbered way wins in both searches
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!row.valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  assign any_free = ~&row.valid;
  assign victim   = any_free ? free_way : tag[WAY_W-1:0];

  always_comb begin
    res.hit  = |match;
    res.fill = !res.hit && !action;
    if (res.hit) begin
      res.way = hit_way;
    end else if (res.fill) begin
      res.way = victim;
    end else begin
      res.way = '0;
    end
    row_nxt = row;
    if (res.fill) begin
      row_nxt.valid[victim] = 1'b1;
      row_nxt.tag[victim]   = tag;
    end
  end

endmodule

@@ sv/set_assoc_cache_tag_lookup_top.sv @@
// Tag/valid directory of a 128-set, 8-way, 64-byte-line write-through cache
// with no allocation on write. Each transaction is a read or write of 1 to 4
// bytes; an access inside one line gives one result, an access crossing a
// line is split into one-byte pieces in address order, one result each.
// Read misses allocate the lowest invalid way (else way tag mod 8) and flag a
// line fill. Every piece is a read-modify-write of one directory RAM row (one
// set), read through a registered RAM port; a split access makes one such
// pass per byte piece. After reset the block clears the valid bits in a pass
// over all 128 sets, one set per cycle, and stalls input until it is done. A
// finished result sits in an output register, so the next transaction is
// taken while it waits.
// Depends on satl_pkg, satl_dir_ram and satl_match.
module set_assoc_cache_tag_lookup_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  satl_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output satl_pkg::rsp_t  out_data
);
  import satl_pkg::*;

  state_t state_r, state_nxt;

  logic [SET_W-1:0]  clr_cnt_r;
  logic              act_r;
  logic [ADDR_W-1:0] piece_addr_r;
  logic [LEN_W-1:0]  piece_len_r;
  logic [LEN_W-1:0]  rem_r;        // pieces left, current one included
  logic              out_valid_r;
  rsp_t              out_data_r;

  logic              in_accept;
  logic              slot_free;
  logic              out_load;

  // directory RAM port signals
  logic              rd_en;
  logic [SET_W-1:0]  rd_addr;
  dir_row_t          rd_row;
  logic              wr_en;
  logic [SET_W-1:0]  wr_addr;
  dir_row_t          wr_row;

  logic [SET_W-1:0]  cur_set;
  logic [TAG_W-1:0]  cur_tag;
  lkp_res_t          lkp;
  dir_row_t          upd_row;

  // input length normalisation and line-crossing test
  logic [LEN_W-1:0]  len_n;
  logic [OFS_W+1:0]  end_ofs;
  logic              split;

  logic [ADDR_W-1:0] set_ext;
  logic [7:0]        way_ext;
  rsp_t              rsp;

  assign cur_set = piece_addr_r[OFS_W +: SET_W];
  assign cur_tag = piece_addr_r[ADDR_W-1 -: TAG_W];

  always_comb begin
    if (in_data.length == '0) begin
      len_n = LEN_W'(1);
    end else if (in_data.length > LEN_W'(MAX_LEN)) begin
      len_n = LEN_W'(MAX_LEN);
    end else begin
      len_n = in_data.length;
    end
    end_ofs = (OFS_W+2)'(in_data.address[OFS_W-1:0]) + (OFS_W+2)'(len_n);
    split   = end_ofs > (OFS_W+2)'(LINE_BYTES);
  end

  satl_dir_ram #(
    .DEPTH (SETS),
    .WIDTH ($bits(dir_row_t))
  ) u_dir_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  satl_match u_match (
    .row     (rd_row),
    .tag     (cur_tag),
    .action  (act_r),
    .res     (lkp),
    .row_nxt (upd_row)
  );

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          state_nxt = (rem_r == LEN_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOOKUP;
      end
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = cur_set;
    wr_en    = 1'b0;
    wr_addr  = cur_set;
    wr_row   = upd_row;
    out_load = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_row  = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
        rd_addr  = in_data.address[OFS_W +: SET_W];
      end
      ST_LOOKUP: begin
        out_load = slot_free;
        wr_en    = slot_free && lkp.fill;
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // narrow report fields are the low bits of set and way
  assign set_ext = ADDR_W'(cur_set);
  assign way_ext = 8'(lkp.way);

  always_comb begin
    rsp.piece_address = piece_addr_r;
    rsp.piece_length  = piece_len_r;
    rsp.set_index     = set_ext[SETO_W-1:0];
    rsp.hit           = lkp.hit;
    rsp.way           = way_ext[WAYO_W-1:0];
    rsp.line_fill     = lkp.fill;
    rsp.write_through = act_r;
    rsp.last          = (rem_r == LEN_W'(1));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r        <= in_data.action;
      piece_addr_r <= in_data.address;
      piece_len_r  <= split ? LEN_W'(1) : len_n;
      rem_r        <= split ? len_n : LEN_W'(1);
    end else if (out_load) begin
      piece_addr_r <= piece_addr_r + ADDR_W'(1);
      rem_r        <= rem_r - LEN_W'(1);
    end
    if (out_load) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a hit never triggers a fill, and writes never fill
  a_fill_only_on_read_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(lkp.fill && (lkp.hit || act_r)))
    else $error("line fill on hit or write");

  // no transaction taken while the valid bits are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall && !out_valid_r)
    else $error("activity during clearing pass");

  // directory written only by the clearing pass or a read-miss lookup
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_CLEAR) || (state_r == ST_LOOKUP && lkp.fill))
    else $error("unexpected directory write");

  // a lookup always has a piece outstanding
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOKUP |-> rem_r != '0)
    else $error("lookup with no piece left");

endmodule
